FILE: rtl/stq_pkg.sv
// Shared constants, codes and types of the sorted timer queue.
package stq_pkg;

   localparam int DEFAULT_DEPTH       = 32;
   localparam int DEFAULT_HANDLE_BITS = 10;
   localparam int EXPIRY_BITS         = 32;
   localparam int MODE_BITS           = 2;
   localparam int STATUS_BITS         = 2;

   // request modes
   localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_ADJUST = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_DELETE = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_TICK   = 2'd3;

   // response status codes
   localparam logic [STATUS_BITS-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_EXPIRED   = 2'd3;

   // per-cell operations broadcast along the chain
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_REMOVE = 2'd2;
   localparam logic [1:0] CELL_POP    = 2'd3;

   typedef struct packed {
      logic [1:0]             op;
      logic [EXPIRY_BITS-1:0] key_expiry;
   } cell_ctrl_type;

endpackage

FILE: rtl/stq_if.sv
// Request and response channel interfaces of the sorted timer queue.
interface stq_req_if #(
   parameter int HANDLE_BITS = stq_pkg::DEFAULT_HANDLE_BITS
);
   import stq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [MODE_BITS-1:0]   mode;
   logic [HANDLE_BITS-1:0] handle;
   logic [EXPIRY_BITS-1:0] new_expiry;
   logic [EXPIRY_BITS-1:0] now_time;

   modport source (output valid, mode, handle, new_expiry, now_time, input ready);
   modport sink   (input valid, mode, handle, new_expiry, now_time, output ready);
endinterface

interface stq_rsp_if #(
   parameter int HANDLE_BITS = stq_pkg::DEFAULT_HANDLE_BITS,
   parameter int COUNT_BITS  = $clog2(stq_pkg::DEFAULT_DEPTH + 1)
);
   import stq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [HANDLE_BITS-1:0] expired_handle;
   logic                   last_result;
   logic [COUNT_BITS-1:0]  occupancy;

   modport source (output valid, status, expired_handle, last_result, occupancy,
                   input ready);
   modport sink   (input valid, status, expired_handle, last_result, occupancy,
                   output ready);
endinterface

FILE: rtl/stq_cell.sv
// One entry cell of the sorted chain: holds a timer and shifts with its neighbors.
module stq_cell #(
   parameter int HANDLE_BITS = stq_pkg::DEFAULT_HANDLE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  stq_pkg::cell_ctrl_type          ctrl,
   input  logic [HANDLE_BITS-1:0]          key_handle,
   input  logic                            left_valid,
   input  logic [stq_pkg::EXPIRY_BITS-1:0] left_expiry,
   input  logic [HANDLE_BITS-1:0]          left_handle,
   input  logic                            left_take,
   input  logic                            right_valid,
   input  logic [stq_pkg::EXPIRY_BITS-1:0] right_expiry,
   input  logic [HANDLE_BITS-1:0]          right_handle,
   input  logic                            seen_in,
   output logic                            valid,
   output logic [stq_pkg::EXPIRY_BITS-1:0] expiry,
   output logic [HANDLE_BITS-1:0]          handle,
   output logic                            take,
   output logic                            seen_out
);
   import stq_pkg::*;

   logic                   valid_ff, valid_in;
   logic [EXPIRY_BITS-1:0] expiry_ff, expiry_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;

   // an empty cell or a later expiry gives way to the new entry
   assign take     = !valid_ff || (expiry_ff > ctrl.key_expiry);
   assign seen_out = seen_in || (valid_ff && (handle_ff == key_handle));

   always_comb begin
      valid_in  = valid_ff;
      expiry_in = expiry_ff;
      handle_in = handle_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (take) begin
               if (left_take) begin
                  valid_in  = left_valid;
                  expiry_in = left_expiry;
                  handle_in = left_handle;
               end else begin
                  valid_in  = 1'b1;
                  expiry_in = ctrl.key_expiry;
                  handle_in = key_handle;
               end
            end
         end
         CELL_REMOVE: begin
            if (seen_out) begin
               valid_in  = right_valid;
               expiry_in = right_expiry;
               handle_in = right_handle;
            end
         end
         CELL_POP: begin
            valid_in  = right_valid;
            expiry_in = right_expiry;
            handle_in = right_handle;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      expiry_ff <= expiry_in;
      handle_ff <= handle_in;
   end

   assign valid  = valid_ff;
   assign expiry = expiry_ff;
   assign handle = handle_ff;

endmodule

FILE: rtl/sorted_timer_queue_top.sv
// Top level of the sorted timer queue: control sequencer around a chain of entry cells.
//
//   channel   dir   handshake       word contents
//   req_chan  in    valid / ready   mode, handle, new_expiry, now_time
//   rsp_chan  out   valid / ready   status, expired_handle, last_result, occupancy
//
// Sequencing: a word is taken only while the sequencer is idle. Insert and delete
// load their result from the run state, adjust after a remove pass and then an
// insert pass, and tick moves from the run state to the tick state, where it pops
// one due entry per cycle while the response register is free, as the chain moves
// by one cell per pop. The next word is accepted once the final result is loaded.
// Reset: synchronous; clears the cell valid bits, the entry count, the sequencer and the response valid bit.
// Stalls: a full response register that is not being read holds the sequencer and the chain in place.
module sorted_timer_queue_top #(
   parameter int DEPTH       = stq_pkg::DEFAULT_DEPTH,
   parameter int HANDLE_BITS = stq_pkg::DEFAULT_HANDLE_BITS
) (
   input  logic       clock,
   input  logic       reset,
   stq_req_if.sink    req_chan,
   stq_rsp_if.source  rsp_chan
);
   import stq_pkg::*;

   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_ADJUST = 2'd2;
   localparam logic [1:0] ST_TICK   = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   // latched request word
   logic [MODE_BITS-1:0]   mode_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [EXPIRY_BITS-1:0] expiry_ff;
   logic [EXPIRY_BITS-1:0] now_ff;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [HANDLE_BITS-1:0] exp_handle_ff, exp_handle_in;
   logic                   last_ff, last_in;
   logic [COUNT_BITS-1:0]  occ_ff;
   logic                   rsp_load;

   cell_ctrl_type          ctrl;

   // chain wiring; index DEPTH is the empty slot past the tail
   logic                   cell_valid  [DEPTH+1];
   logic [EXPIRY_BITS-1:0] cell_expiry [DEPTH+1];
   logic [HANDLE_BITS-1:0] cell_handle [DEPTH+1];
   logic                   cell_take   [DEPTH];
   logic                   cell_seen   [DEPTH];

   logic accept;
   logic slot_free;
   logic found;
   logic head_due;
   logic next_due;

   assign cell_valid[DEPTH]  = 1'b0;
   assign cell_expiry[DEPTH] = '0;
   assign cell_handle[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                   l_valid;
      logic [EXPIRY_BITS-1:0] l_expiry;
      logic [HANDLE_BITS-1:0] l_handle;
      logic                   l_take;
      logic                   l_seen;

      if (i == 0) begin : g_head
         assign l_valid  = 1'b0;
         assign l_expiry = '0;
         assign l_handle = '0;
         assign l_take   = 1'b0;
         assign l_seen   = 1'b0;
      end else begin : g_body
         assign l_valid  = cell_valid[i-1];
         assign l_expiry = cell_expiry[i-1];
         assign l_handle = cell_handle[i-1];
         assign l_take   = cell_take[i-1];
         assign l_seen   = cell_seen[i-1];
      end

      stq_cell #(
         .HANDLE_BITS (HANDLE_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .key_handle   (handle_ff),
         .left_valid   (l_valid),
         .left_expiry  (l_expiry),
         .left_handle  (l_handle),
         .left_take    (l_take),
         .right_valid  (cell_valid[i+1]),
         .right_expiry (cell_expiry[i+1]),
         .right_handle (cell_handle[i+1]),
         .seen_in      (l_seen),
         .valid        (cell_valid[i]),
         .expiry       (cell_expiry[i]),
         .handle       (cell_handle[i]),
         .take         (cell_take[i]),
         .seen_out     (cell_seen[i])
      );
   end

   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   // the seen flag ripples down the chain; at the tail it says the handle exists
   assign found     = cell_seen[DEPTH-1];
   assign head_due  = cell_valid[0] && (cell_expiry[0] <= now_ff);
   assign next_due  = cell_valid[1] && (cell_expiry[1] <= now_ff);

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ctrl.op        = CELL_HOLD;
      ctrl.key_expiry = expiry_ff;
      rsp_load       = 1'b0;
      status_in      = STATUS_DONE;
      exp_handle_in  = '0;
      last_in        = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (slot_free) begin
               unique case (mode_ff)
                  MODE_INSERT: begin
                     rsp_load = 1'b1;
                     state_in = ST_IDLE;
                     if (count_ff == COUNT_BITS'(DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ctrl.op  = CELL_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  MODE_ADJUST: begin
                     if (found) begin
                        // take the entry out now, place it again next cycle
                        ctrl.op  = CELL_REMOVE;
                        count_in = count_ff - 1'b1;
                        state_in = ST_ADJUST;
                     end else begin
                        rsp_load  = 1'b1;
                        status_in = STATUS_NOT_FOUND;
                        state_in  = ST_IDLE;
                     end
                  end
                  MODE_DELETE: begin
                     rsp_load = 1'b1;
                     state_in = ST_IDLE;
                     if (found) begin
                        ctrl.op  = CELL_REMOVE;
                        count_in = count_ff - 1'b1;
                     end else begin
                        status_in = STATUS_NOT_FOUND;
                     end
                  end
                  MODE_TICK: begin
                     state_in = ST_TICK;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ADJUST: begin
            // slot was free when the remove pass ran and nothing was loaded since
            ctrl.op  = CELL_INSERT;
            count_in = count_ff + 1'b1;
            rsp_load = 1'b1;
            state_in = ST_IDLE;
         end
         ST_TICK: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               if (head_due) begin
                  // pop the head and report it; stop once the next one is not due
                  ctrl.op       = CELL_POP;
                  count_in      = count_ff - 1'b1;
                  status_in     = STATUS_EXPIRED;
                  exp_handle_in = cell_handle[0];
                  last_in       = !next_due;
                  if (!next_due) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: hold the request word, load the response word
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_chan.mode;
         handle_ff <= req_chan.handle;
         expiry_ff <= req_chan.new_expiry;
         now_ff    <= req_chan.now_time;
      end
      if (rsp_load) begin
         status_ff     <= status_in;
         exp_handle_ff <= exp_handle_in;
         last_ff       <= last_in;
         occ_ff        <= count_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.expired_handle = exp_handle_ff;
   assign rsp_chan.last_result    = last_ff;
   assign rsp_chan.occupancy      = occ_ff;

endmodule
